// File: sv/hpack_pkg.sv
// Package for the HPACK static Huffman byte encoder.
// Holds item structs, widths and the Huffman code table function; no dependencies.
package hpack_pkg;

	localparam int SymW     = 8;
	localparam int CodeW    = 30;
	localparam int LenW     = 5;
	localparam int AccW     = CodeW + 7;
	localparam int CntW     = 6;
	localparam int MaxBytes = 5;

	typedef struct packed {
		logic [7:0] symbol;
		logic       final_symbol;
	} in_item_t;

	typedef struct packed {
		logic [7:0] coded_byte;
		logic       run_last;
		logic       string_end;
	} out_item_t;

	typedef struct packed {
		logic [CodeW-1:0] code;
		logic [LenW-1:0]  len;
	} huff_entry_t;

	// Code table, RFC 7541 Appendix B, byte symbols only
	function automatic huff_entry_t huff_lookup(input logic [7:0] sym);
		logic [35:0] e;
		begin
			case (sym)
				8'd0: e = {30'h1ff8, 6'd13}; 8'd1: e = {30'h7fffd8, 6'd23};
				8'd2: e = {30'hfffffe2, 6'd28}; 8'd3: e = {30'hfffffe3, 6'd28};
				8'd4: e = {30'hfffffe4, 6'd28}; 8'd5: e = {30'hfffffe5, 6'd28};
				8'd6: e = {30'hfffffe6, 6'd28}; 8'd7: e = {30'hfffffe7, 6'd28};
				8'd8: e = {30'hfffffe8, 6'd28}; 8'd9: e = {30'hffffea, 6'd24};
				8'd10: e = {30'h3ffffffc, 6'd30}; 8'd11: e = {30'hfffffe9, 6'd28};
				8'd12: e = {30'hfffffea, 6'd28}; 8'd13: e = {30'h3ffffffd, 6'd30};
				8'd14: e = {30'hfffffeb, 6'd28}; 8'd15: e = {30'hfffffec, 6'd28};
				8'd16: e = {30'hfffffed, 6'd28}; 8'd17: e = {30'hfffffee, 6'd28};
				8'd18: e = {30'hfffffef, 6'd28}; 8'd19: e = {30'hffffff0, 6'd28};
				8'd20: e = {30'hffffff1, 6'd28}; 8'd21: e = {30'hffffff2, 6'd28};
				8'd22: e = {30'h3ffffffe, 6'd30}; 8'd23: e = {30'hffffff3, 6'd28};
				8'd24: e = {30'hffffff4, 6'd28}; 8'd25: e = {30'hffffff5, 6'd28};
				8'd26: e = {30'hffffff6, 6'd28}; 8'd27: e = {30'hffffff7, 6'd28};
				8'd28: e = {30'hffffff8, 6'd28}; 8'd29: e = {30'hffffff9, 6'd28};
				8'd30: e = {30'hffffffa, 6'd28}; 8'd31: e = {30'hffffffb, 6'd28};
				8'd32: e = {30'h14, 6'd6}; 8'd33: e = {30'h3f8, 6'd10};
				8'd34: e = {30'h3f9, 6'd10}; 8'd35: e = {30'hffa, 6'd12};
				8'd36: e = {30'h1ff9, 6'd13}; 8'd37: e = {30'h15, 6'd6};
				8'd38: e = {30'hf8, 6'd8}; 8'd39: e = {30'h7fa, 6'd11};
				8'd40: e = {30'h3fa, 6'd10}; 8'd41: e = {30'h3fb, 6'd10};
				8'd42: e = {30'hf9, 6'd8}; 8'd43: e = {30'h7fb, 6'd11};
				8'd44: e = {30'hfa, 6'd8}; 8'd45: e = {30'h16, 6'd6};
				8'd46: e = {30'h17, 6'd6}; 8'd47: e = {30'h18, 6'd6};
				8'd48: e = {30'h0, 6'd5}; 8'd49: e = {30'h1, 6'd5};
				8'd50: e = {30'h2, 6'd5}; 8'd51: e = {30'h19, 6'd6};
				8'd52: e = {30'h1a, 6'd6}; 8'd53: e = {30'h1b, 6'd6};
				8'd54: e = {30'h1c, 6'd6}; 8'd55: e = {30'h1d, 6'd6};
				8'd56: e = {30'h1e, 6'd6}; 8'd57: e = {30'h1f, 6'd6};
				8'd58: e = {30'h5c, 6'd7}; 8'd59: e = {30'hfb, 6'd8};
				8'd60: e = {30'h7ffc, 6'd15}; 8'd61: e = {30'h20, 6'd6};
				8'd62: e = {30'hffb, 6'd12}; 8'd63: e = {30'h3fc, 6'd10};
				8'd64: e = {30'h1ffa, 6'd13}; 8'd65: e = {30'h21, 6'd6};
				8'd66: e = {30'h5d, 6'd7}; 8'd67: e = {30'h5e, 6'd7};
				8'd68: e = {30'h5f, 6'd7}; 8'd69: e = {30'h60, 6'd7};
				8'd70: e = {30'h61, 6'd7}; 8'd71: e = {30'h62, 6'd7};
				8'd72: e = {30'h63, 6'd7}; 8'd73: e = {30'h64, 6'd7};
				8'd74: e = {30'h65, 6'd7}; 8'd75: e = {30'h66, 6'd7};
				8'd76: e = {30'h67, 6'd7}; 8'd77: e = {30'h68, 6'd7};
				8'd78: e = {30'h69, 6'd7}; 8'd79: e = {30'h6a, 6'd7};
				8'd80: e = {30'h6b, 6'd7}; 8'd81: e = {30'h6c, 6'd7};
				8'd82: e = {30'h6d, 6'd7}; 8'd83: e = {30'h6e, 6'd7};
				8'd84: e = {30'h6f, 6'd7}; 8'd85: e = {30'h70, 6'd7};
				8'd86: e = {30'h71, 6'd7}; 8'd87: e = {30'h72, 6'd7};
				8'd88: e = {30'hfc, 6'd8}; 8'd89: e = {30'h73, 6'd7};
				8'd90: e = {30'hfd, 6'd8}; 8'd91: e = {30'h1ffb, 6'd13};
				8'd92: e = {30'h7fff0, 6'd19}; 8'd93: e = {30'h1ffc, 6'd13};
				8'd94: e = {30'h3ffc, 6'd14}; 8'd95: e = {30'h22, 6'd6};
				8'd96: e = {30'h7ffd, 6'd15}; 8'd97: e = {30'h3, 6'd5};
				8'd98: e = {30'h23, 6'd6}; 8'd99: e = {30'h4, 6'd5};
				8'd100: e = {30'h24, 6'd6}; 8'd101: e = {30'h5, 6'd5};
				8'd102: e = {30'h25, 6'd6}; 8'd103: e = {30'h26, 6'd6};
				8'd104: e = {30'h27, 6'd6}; 8'd105: e = {30'h6, 6'd5};
				8'd106: e = {30'h74, 6'd7}; 8'd107: e = {30'h75, 6'd7};
				8'd108: e = {30'h28, 6'd6}; 8'd109: e = {30'h29, 6'd6};
				8'd110: e = {30'h2a, 6'd6}; 8'd111: e = {30'h7, 6'd5};
				8'd112: e = {30'h2b, 6'd6}; 8'd113: e = {30'h76, 6'd7};
				8'd114: e = {30'h2c, 6'd6}; 8'd115: e = {30'h8, 6'd5};
				8'd116: e = {30'h9, 6'd5}; 8'd117: e = {30'h2d, 6'd6};
				8'd118: e = {30'h77, 6'd7}; 8'd119: e = {30'h78, 6'd7};
				8'd120: e = {30'h79, 6'd7}; 8'd121: e = {30'h7a, 6'd7};
				8'd122: e = {30'h7b, 6'd7}; 8'd123: e = {30'h7ffe, 6'd15};
				8'd124: e = {30'h7fc, 6'd11}; 8'd125: e = {30'h3ffd, 6'd14};
				8'd126: e = {30'h1ffd, 6'd13}; 8'd127: e = {30'hffffffc, 6'd28};
				8'd128: e = {30'hfffe6, 6'd20}; 8'd129: e = {30'h3fffd2, 6'd22};
				8'd130: e = {30'hfffe7, 6'd20}; 8'd131: e = {30'hfffe8, 6'd20};
				8'd132: e = {30'h3fffd3, 6'd22}; 8'd133: e = {30'h3fffd4, 6'd22};
				8'd134: e = {30'h3fffd5, 6'd22}; 8'd135: e = {30'h7fffd9, 6'd23};
				8'd136: e = {30'h3fffd6, 6'd22}; 8'd137: e = {30'h7fffda, 6'd23};
				8'd138: e = {30'h7fffdb, 6'd23}; 8'd139: e = {30'h7fffdc, 6'd23};
				8'd140: e = {30'h7fffdd, 6'd23}; 8'd141: e = {30'h7fffde, 6'd23};
				8'd142: e = {30'hffffeb, 6'd24}; 8'd143: e = {30'h7fffdf, 6'd23};
				8'd144: e = {30'hffffec, 6'd24}; 8'd145: e = {30'hffffed, 6'd24};
				8'd146: e = {30'h3fffd7, 6'd22}; 8'd147: e = {30'h7fffe0, 6'd23};
				8'd148: e = {30'hffffee, 6'd24}; 8'd149: e = {30'h7fffe1, 6'd23};
				8'd150: e = {30'h7fffe2, 6'd23}; 8'd151: e = {30'h7fffe3, 6'd23};
				8'd152: e = {30'h7fffe4, 6'd23}; 8'd153: e = {30'h1fffdc, 6'd21};
				8'd154: e = {30'h3fffd8, 6'd22}; 8'd155: e = {30'h7fffe5, 6'd23};
				8'd156: e = {30'h3fffd9, 6'd22}; 8'd157: e = {30'h7fffe6, 6'd23};
				8'd158: e = {30'h7fffe7, 6'd23}; 8'd159: e = {30'hffffef, 6'd24};
				8'd160: e = {30'h3fffda, 6'd22}; 8'd161: e = {30'h1fffdd, 6'd21};
				8'd162: e = {30'hfffe9, 6'd20}; 8'd163: e = {30'h3fffdb, 6'd22};
				8'd164: e = {30'h3fffdc, 6'd22}; 8'd165: e = {30'h7fffe8, 6'd23};
				8'd166: e = {30'h7fffe9, 6'd23}; 8'd167: e = {30'h1fffde, 6'd21};
				8'd168: e = {30'h7fffea, 6'd23}; 8'd169: e = {30'h3fffdd, 6'd22};
				8'd170: e = {30'h3fffde, 6'd22}; 8'd171: e = {30'hfffff0, 6'd24};
				8'd172: e = {30'h1fffdf, 6'd21}; 8'd173: e = {30'h3fffdf, 6'd22};
				8'd174: e = {30'h7fffeb, 6'd23}; 8'd175: e = {30'h7fffec, 6'd23};
				8'd176: e = {30'h1fffe0, 6'd21}; 8'd177: e = {30'h1fffe1, 6'd21};
				8'd178: e = {30'h3fffe0, 6'd22}; 8'd179: e = {30'h1fffe2, 6'd21};
				8'd180: e = {30'h7fffed, 6'd23}; 8'd181: e = {30'h3fffe1, 6'd22};
				8'd182: e = {30'h7fffee, 6'd23}; 8'd183: e = {30'h7fffef, 6'd23};
				8'd184: e = {30'hfffea, 6'd20}; 8'd185: e = {30'h3fffe2, 6'd22};
				8'd186: e = {30'h3fffe3, 6'd22}; 8'd187: e = {30'h3fffe4, 6'd22};
				8'd188: e = {30'h7ffff0, 6'd23}; 8'd189: e = {30'h3fffe5, 6'd22};
				8'd190: e = {30'h3fffe6, 6'd22}; 8'd191: e = {30'h7ffff1, 6'd23};
				8'd192: e = {30'h3ffffe0, 6'd26}; 8'd193: e = {30'h3ffffe1, 6'd26};
				8'd194: e = {30'hfffeb, 6'd20}; 8'd195: e = {30'h7fff1, 6'd19};
				8'd196: e = {30'h3fffe7, 6'd22}; 8'd197: e = {30'h7ffff2, 6'd23};
				8'd198: e = {30'h3fffe8, 6'd22}; 8'd199: e = {30'h1ffffec, 6'd25};
				8'd200: e = {30'h3ffffe2, 6'd26}; 8'd201: e = {30'h3ffffe3, 6'd26};
				8'd202: e = {30'h3ffffe4, 6'd26}; 8'd203: e = {30'h7ffffde, 6'd27};
				8'd204: e = {30'h7ffffdf, 6'd27}; 8'd205: e = {30'h3ffffe5, 6'd26};
				8'd206: e = {30'hfffff1, 6'd24}; 8'd207: e = {30'h1ffffed, 6'd25};
				8'd208: e = {30'h7fff2, 6'd19}; 8'd209: e = {30'h1fffe3, 6'd21};
				8'd210: e = {30'h3ffffe6, 6'd26}; 8'd211: e = {30'h7ffffe0, 6'd27};
				8'd212: e = {30'h7ffffe1, 6'd27}; 8'd213: e = {30'h3ffffe7, 6'd26};
				8'd214: e = {30'h7ffffe2, 6'd27}; 8'd215: e = {30'hfffff2, 6'd24};
				8'd216: e = {30'h1fffe4, 6'd21}; 8'd217: e = {30'h1fffe5, 6'd21};
				8'd218: e = {30'h3ffffe8, 6'd26}; 8'd219: e = {30'h3ffffe9, 6'd26};
				8'd220: e = {30'hffffffd, 6'd28}; 8'd221: e = {30'h7ffffe3, 6'd27};
				8'd222: e = {30'h7ffffe4, 6'd27}; 8'd223: e = {30'h7ffffe5, 6'd27};
				8'd224: e = {30'hfffec, 6'd20}; 8'd225: e = {30'hfffff3, 6'd24};
				8'd226: e = {30'hfffed, 6'd20}; 8'd227: e = {30'h1fffe6, 6'd21};
				8'd228: e = {30'h3fffe9, 6'd22}; 8'd229: e = {30'h1fffe7, 6'd21};
				8'd230: e = {30'h1fffe8, 6'd21}; 8'd231: e = {30'h7ffff3, 6'd23};
				8'd232: e = {30'h3fffea, 6'd22}; 8'd233: e = {30'h3fffeb, 6'd22};
				8'd234: e = {30'h1ffffee, 6'd25}; 8'd235: e = {30'h1ffffef, 6'd25};
				8'd236: e = {30'hfffff4, 6'd24}; 8'd237: e = {30'hfffff5, 6'd24};
				8'd238: e = {30'h3ffffea, 6'd26}; 8'd239: e = {30'h7ffff4, 6'd23};
				8'd240: e = {30'h3ffffeb, 6'd26}; 8'd241: e = {30'h7ffffe6, 6'd27};
				8'd242: e = {30'h3ffffec, 6'd26}; 8'd243: e = {30'h3ffffed, 6'd26};
				8'd244: e = {30'h7ffffe7, 6'd27}; 8'd245: e = {30'h7ffffe8, 6'd27};
				8'd246: e = {30'h7ffffe9, 6'd27}; 8'd247: e = {30'h7ffffea, 6'd27};
				8'd248: e = {30'h7ffffeb, 6'd27}; 8'd249: e = {30'hffffffe, 6'd28};
				8'd250: e = {30'h7ffffec, 6'd27}; 8'd251: e = {30'h7ffffed, 6'd27};
				8'd252: e = {30'h7ffffee, 6'd27}; 8'd253: e = {30'h7ffffef, 6'd27};
				8'd254: e = {30'h7fffff0, 6'd27}; 8'd255: e = {30'h3ffffee, 6'd26};
				default: e = {30'h1ff8, 6'd13};
			endcase
			huff_lookup.code = e[35:6];
			huff_lookup.len  = e[4:0];
		end
	endfunction

endpackage

// File: sv/hpack_pack.sv
// Bit packer: looks up each symbol's code, merges it with pending bits, and
// registers a left-aligned run of whole bytes. Depends on hpack_pkg.
module hpack_pack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  hpack_pkg::in_item_t    in_item,
	output logic                   run_valid,
	input  logic                   run_take,
	output logic [39:0]            run_bytes,
	output logic [2:0]             run_count,
	output logic                   run_fin
);

	logic [6:0]  pend_bits_q;
	logic [2:0]  pend_cnt_q;
	logic        run_valid_q;
	logic [39:0] run_bytes_q;
	logic [2:0]  run_count_q;
	logic        run_fin_q;

	hpack_pkg::huff_entry_t ent;
	logic [hpack_pkg::AccW-1:0] acc;
	logic [5:0]  total;
	logic [2:0]  rem;
	logic [2:0]  nbytes;
	logic [2:0]  nout;
	logic [39:0] aligned;
	logic [39:0] padded;
	logic [6:0]  keep;
	logic        accept;

	assign in_ready = !run_valid_q || run_take;
	assign accept   = in_valid && in_ready;

	// Merge the code below the pending bits and left-align the whole run
	always_comb begin
		ent     = hpack_pkg::huff_lookup(in_item.symbol);
		acc     = ({30'd0, pend_bits_q} << ent.len) | {7'd0, ent.code};
		total   = {3'd0, pend_cnt_q} + {1'b0, ent.len};
		rem     = total[2:0];
		nbytes  = total[5:3];
		aligned = 40'({3'd0, acc} << (6'd40 - total));
		// Pad the tail with ones on the last symbol of the string
		padded  = aligned | (40'hFF_FFFF_FFFF >> total);
		keep    = 7'(acc & ((37'd1 << rem) - 37'd1));
		if (in_item.final_symbol && rem != 3'd0)
			nout = nbytes + 3'd1;
		else
			nout = nbytes;
	end

	// Hold pending bits and the output run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			run_valid_q <= 1'b0;
		end else begin
			if (run_take)
				run_valid_q <= 1'b0;
			if (accept) begin
				run_valid_q <= (nout != 3'd0);
				if (in_item.final_symbol) begin
					pend_bits_q <= '0;
					pend_cnt_q  <= '0;
				end else begin
					pend_bits_q <= keep;
					pend_cnt_q  <= rem;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_bytes_q <= in_item.final_symbol ? padded : aligned;
			run_count_q <= nout;
			run_fin_q   <= in_item.final_symbol;
		end
	end

	assign run_valid = run_valid_q;
	assign run_bytes = run_bytes_q;
	assign run_count = run_count_q;
	assign run_fin   = run_fin_q;

endmodule

// File: sv/hpack_emit.sv
// Byte emitter: shifts a registered run out one item per cycle, while the
// receiver keeps out_ready high, into an output register. Depends on hpack_pkg.
module hpack_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  run_valid,
	output logic                  run_take,
	input  logic [39:0]           run_bytes,
	input  logic [2:0]            run_count,
	input  logic                  run_fin,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hpack_pkg::out_item_t  out_item
);

	logic [2:0]           idx_q;
	logic                 out_valid_q;
	hpack_pkg::out_item_t out_q;
	logic                 load;
	logic                 last_byte;

	assign last_byte = (idx_q + 3'd1 == run_count);
	assign load      = run_valid && (!out_valid_q || out_ready);
	assign run_take  = load && last_byte;

	// Advance through the run, one byte per cycle while the output is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_byte ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.coded_byte <= 8'(run_bytes >> (6'd32 - {idx_q, 3'd0}));
			out_q.run_last   <= last_byte;
			out_q.string_end <= last_byte && run_fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: sv/hpack_huffman_byte_encoder_core.sv
// HPACK static Huffman byte encoder: one string byte in per item, coded bytes
// out MSB first, padded with ones at the string end. Depends on hpack_pkg.
//
// An input item is registered as a run of 0 to 5 output bytes; the result
// port then emits one byte per cycle while out_ready is high. A symbol thus
// yields as many output bytes as it completes (0 to 5), and the next symbol
// is taken in the cycle its predecessor's last byte moves out.
// The single-byte result port sets the sustained rate.
module hpack_huffman_byte_encoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hpack_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hpack_pkg::out_item_t out_item
);

	logic        run_valid;
	logic        run_take;
	logic [39:0] run_bytes;
	logic [2:0]  run_count;
	logic        run_fin;

	hpack_pack u_pack (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.run_valid, .run_take, .run_bytes, .run_count, .run_fin
	);

	hpack_emit u_emit (
		.clk, .arst_n, .run_valid, .run_take, .run_bytes, .run_count, .run_fin,
		.out_valid, .out_ready, .out_item
	);

endmodule

// File: sim/testbench.sv
// Self-checking bench for the HPACK static Huffman byte encoder core.
// Drives random and directed string bytes, predicts coded bytes; depends on hpack_pkg.
module testbench;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	hpack_pkg::in_item_t  in_item;
	logic                 out_valid;
	logic                 out_ready;
	hpack_pkg::out_item_t out_item;

	int errors;
	int idle_cycles;
	bit hold_off;

	localparam int WatchLimit = 5000;

	// Code table: RFC 7541 Appendix B, byte symbols only, as {code, length}
	typedef struct packed {
		logic [29:0] code;
		logic [4:0]  len;
	} code_t;
	code_t code_rom [256];

	initial begin
		logic [29:0] c [256];
		int          l [256];
		c = '{30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3, 30'hfffffe4, 30'hfffffe5,
			30'hfffffe6, 30'hfffffe7, 30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
			30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec, 30'hfffffed, 30'hfffffee,
			30'hfffffef, 30'hffffff0, 30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
			30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7, 30'hffffff8, 30'hffffff9,
			30'hffffffa, 30'hffffffb, 30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15,
			30'hf8, 30'h7fa, 30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17,
			30'h18, 30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d, 30'h1e,
			30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc, 30'h1ffa, 30'h21,
			30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62, 30'h63, 30'h64, 30'h65, 30'h66,
			30'h67, 30'h68, 30'h69, 30'h6a, 30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70,
			30'h71, 30'h72, 30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc,
			30'h22, 30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26, 30'h27,
			30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7, 30'h2b, 30'h76, 30'h2c,
			30'h8, 30'h9, 30'h2d, 30'h77, 30'h78, 30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc,
			30'h3ffd, 30'h1ffd, 30'hffffffc, 30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8,
			30'h3fffd3, 30'h3fffd4, 30'h3fffd5, 30'h7fffd9, 30'h3fffd6, 30'h7fffda,
			30'h7fffdb, 30'h7fffdc, 30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf,
			30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0, 30'hffffee, 30'h7fffe1,
			30'h7fffe2, 30'h7fffe3, 30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
			30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef, 30'h3fffda, 30'h1fffdd,
			30'hfffe9, 30'h3fffdb, 30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde,
			30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0, 30'h1fffdf, 30'h3fffdf,
			30'h7fffeb, 30'h7fffec, 30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
			30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef, 30'hfffea, 30'h3fffe2,
			30'h3fffe3, 30'h3fffe4, 30'h7ffff0, 30'h3fffe5, 30'h3fffe6, 30'h7ffff1,
			30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1, 30'h3fffe7, 30'h7ffff2,
			30'h3fffe8, 30'h1ffffec, 30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
			30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed, 30'h7fff2, 30'h1fffe3,
			30'h3ffffe6, 30'h7ffffe0, 30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2,
			30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9, 30'hffffffd, 30'h7ffffe3,
			30'h7ffffe4, 30'h7ffffe5, 30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6,
			30'h3fffe9, 30'h1fffe7, 30'h1fffe8, 30'h7ffff3, 30'h3fffea, 30'h3fffeb,
			30'h1ffffee, 30'h1ffffef, 30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
			30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed, 30'h7ffffe7, 30'h7ffffe8,
			30'h7ffffe9, 30'h7ffffea, 30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed,
			30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee};
		l = '{13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
			28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
			6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
			5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
			13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
			7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
			15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
			6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
			20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
			24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
			22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
			21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
			26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
			19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
			20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
			26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26};
		for (int i = 0; i < 256; i++) begin
			code_rom[i].code = c[i];
			code_rom[i].len  = 5'(l[i]);
		end
	end

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// Bit-packing predictor and queue of expected coded bytes
	class coded_byte_board;
		logic [6:0]           held_bits = '0;
		int                   held_count;
		hpack_pkg::out_item_t expected_bytes[$];
		int                   bytes_seen;
		int                   strings_seen;

		function void note_symbol(hpack_pkg::in_item_t it);
			logic [36:0]          acc;
			int                   n;
			int                   first;
			hpack_pkg::out_item_t r;
			code_t                e;
			e     = code_rom[it.symbol];
			acc   = ({30'd0, held_bits} << e.len) | 37'(e.code);
			n     = held_count + e.len;
			first = expected_bytes.size();
			while (n >= 8) begin
				n = n - 8;
				r = '{coded_byte: 8'(acc >> n), run_last: 1'b0, string_end: 1'b0};
				expected_bytes.push_back(r);
				acc = acc & ((37'd1 << n) - 1);
			end
			// pad the tail with ones up to a byte boundary
			if (it.final_symbol && n > 0) begin
				r.coded_byte = 8'((acc << (8 - n)) | ((37'd1 << (8 - n)) - 1));
				r.run_last   = 1'b0;
				r.string_end = 1'b0;
				expected_bytes.push_back(r);
				n   = 0;
				acc = 0;
			end
			if (expected_bytes.size() > first) begin
				expected_bytes[$].run_last   = 1'b1;
				expected_bytes[$].string_end = it.final_symbol;
			end
			if (it.final_symbol)
				strings_seen++;
			held_bits  = acc[6:0];
			held_count = n;
		endfunction

		task check_byte(hpack_pkg::out_item_t got);
			hpack_pkg::out_item_t want;
			bytes_seen++;
			if (expected_bytes.size() == 0) begin
				$display("unexpected coded byte %0h at %0t", got.coded_byte, $time);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (got.coded_byte !== want.coded_byte)
					report("coded_byte", got.coded_byte, want.coded_byte);
				if (got.run_last !== want.run_last)
					report("run_last", 8'(got.run_last), 8'(want.run_last));
				if (got.string_end !== want.string_end)
					report("string_end", 8'(got.string_end), 8'(want.string_end));
			end
		endtask
	endclass

	coded_byte_board board;

	hpack_huffman_byte_encoder_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Offer one item and hold it until taken, after a random gap if gaps is set
	task automatic send_symbol(input logic [7:0] sym, input logic fin, input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid     <= 1'b1;
		in_item      <= '{symbol: sym, final_symbol: fin};
		do @(posedge clk); while (!in_ready);
		board.note_symbol('{symbol: sym, final_symbol: fin});
	endtask

	// Drop the input and wait until every expected result has come
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_bytes.size() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off on request
	initial begin
		int g;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			g = gap_len();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Check every accepted result
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_byte(out_item);

	// Watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchLimit) begin
			$display("watchdog expired at %0t", $time);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int n;
		logic [7:0] sym;
		board       = new();
		errors      = 0;
		idle_cycles = 0;
		hold_off    = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_item     = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: shortest and longest codes, byte-aligned final,
		// final with padding, single-symbol strings
		send_symbol(8'd48, 1'b1, 0);
		send_symbol(8'd38, 1'b1, 0);
		send_symbol(8'd22, 1'b0, 0);
		send_symbol(8'd10, 1'b0, 0);
		send_symbol(8'd13, 1'b1, 0);
		send_symbol(8'd0, 1'b0, 0);
		send_symbol(8'd255, 1'b0, 0);
		send_symbol(8'd97, 1'b0, 0);
		send_symbol(8'd101, 1'b0, 0);
		send_symbol(8'd105, 1'b0, 0);
		send_symbol(8'd111, 1'b1, 0);
		send_symbol(8'd127, 1'b0, 0);
		send_symbol(8'd128, 1'b1, 0);
		send_symbol(8'd170, 1'b0, 0);
		send_symbol(8'd85, 1'b1, 0);
		send_symbol(8'd249, 1'b1, 0);
		send_symbol(8'd22, 1'b1, 0);

		// Pause until everything has drained
		wait_drained();

		// Long receiver hold-off while the sender keeps offering items
		hold_off = 1;
		for (int i = 0; i < 20; i++)
			send_symbol(8'($urandom_range(0, 255)), 1'b0, 0);
		send_symbol(8'd10, 1'b1, 0);

		// Random strings: mostly printable text, some arbitrary bytes
		n = 0;
		while (n < 480) begin
			int len;
			len = $urandom_range(1, 12);
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(0, 3) == 0)
					sym = 8'($urandom_range(0, 255));
				else
					sym = 8'($urandom_range(32, 126));
				send_symbol(sym, j == len - 1, 1);
				n++;
			end
			if ($urandom_range(0, 30) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d strings, checked %0d coded bytes, %0d errors.",
			board.strings_seen, board.bytes_seen, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
sv/hpack_pkg.sv
sv/hpack_pack.sv
sv/hpack_emit.sv
sv/hpack_huffman_byte_encoder_core.sv
sim/testbench.sv
